FILE: src/csig_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csig_pkg
// Shared widths, codes and constants of the cube-sphere index generator.
// ----------------------------------------------------------------------------
package csig_pkg;

  localparam int TYPE_W             = 2;
  localparam int COL_W              = 10;
  localparam int ROW_W              = 8;
  localparam int RES_W              = 9;
  localparam int RING_W             = RES_W + 2;
  localparam int IDX_W              = 19;
  localparam int NUM_IDX            = 6;
  localparam int LEFT_W             = $clog2(NUM_IDX + 1);
  localparam int DEF_MAX_RESOLUTION = 256;
  localparam int MIN_RESOLUTION     = 2;
  localparam logic [RES_W-1:0] RES_RESET = RES_W'(2);

  typedef enum logic [TYPE_W-1:0] {
    REQ_SIDE    = 2'd0,
    REQ_TOP     = 2'd1,
    REQ_BOTTOM  = 2'd2,
    REQ_INVALID = 2'd3
  } req_t;

  typedef logic [IDX_W-1:0] idx_t;

endpackage
`default_nettype wire

FILE: src/cube_sphere_index_generator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cube_sphere_index_generator
// Turns one quad request into the six vertex indices of its two triangles,
// or into one zero index when the request is rejected.
// Path: the first index of a request goes through the input register and then
//   the result buffer, which it enters once the result buffer is free.
// Throughput: one index word per cycle while out_ready is high, set by the
//   single-index result channel; a valid request gives 6 words, a rejected 1.
// Reset: clears both stage valids and loads resolution with 2; ready ports are
//   held low while rst is high.
// ----------------------------------------------------------------------------
module cube_sphere_index_generator
  import csig_pkg::*;
#(
  parameter int MAX_RESOLUTION = DEF_MAX_RESOLUTION
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // configuration write channel
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [RES_W-1:0]  cfg_data,
  // request channel
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [TYPE_W-1:0] req_type,
  input  wire logic [COL_W-1:0]  quad_col,
  input  wire logic [ROW_W-1:0]  quad_row,
  // index channel
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [IDX_W-1:0]       vtx_index,
  output logic                   last,
  output logic                   bad_request
);

  // --------------------------------------------------------------------------
  // Resolution register and the grid constants derived from it. The derived
  // registers load from the clamped next value, so they match it clamped.
  // --------------------------------------------------------------------------
  logic [RES_W-1:0]  resolution, res_next;
  logic [RES_W-1:0]  r_eff;
  logic [RES_W-1:0]  edge_n, edge_n_next;      // R-1
  logic [RES_W-1:0]  inner_w, inner_w_next;    // R-2, interior row width
  logic [RING_W-1:0] ring_len, ring_len_next;  // 4(R-1), side row length
  logic [RING_W-1:0] three_n, three_n_next;    // 3(R-1)
  idx_t              top_base, top_base_next;  // first top interior vertex
  idx_t              bot_base, bot_base_next;  // first bottom interior vertex
  idx_t              bot_off, bot_off_next;    // first vertex of last side row
  idx_t              inner_sq;

  assign cfg_ready = !rst;

  always_comb begin
    res_next = resolution;
    if (rst) begin
      res_next = RES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      res_next = cfg_data;
    end

    // clamp into [2, MAX_RESOLUTION]
    if (int'(res_next) < MIN_RESOLUTION) begin
      r_eff = RES_W'(MIN_RESOLUTION);
    end else if (int'(res_next) > MAX_RESOLUTION) begin
      r_eff = RES_W'(MAX_RESOLUTION);
    end else begin
      r_eff = res_next;
    end

    edge_n_next   = r_eff - RES_W'(1);
    inner_w_next  = r_eff - RES_W'(2);
    ring_len_next = {edge_n_next, 2'b00};
    three_n_next  = ring_len_next - RING_W'(edge_n_next);
    top_base_next = IDX_W'(ring_len_next) * IDX_W'(r_eff);
    inner_sq      = IDX_W'(inner_w_next) * IDX_W'(inner_w_next);
    bot_base_next = top_base_next + inner_sq;
    bot_off_next  = IDX_W'(edge_n_next) * IDX_W'(ring_len_next);
  end

  always_ff @(posedge clk) begin
    resolution <= res_next;
    edge_n     <= edge_n_next;
    inner_w    <= inner_w_next;
    ring_len   <= ring_len_next;
    three_n    <= three_n_next;
    top_base   <= top_base_next;
    bot_base   <= bot_base_next;
    bot_off    <= bot_off_next;
  end

  // --------------------------------------------------------------------------
  // Input register. A new word is taken when it is empty or the held one moves on.
  // --------------------------------------------------------------------------
  logic             s1_valid;
  req_t             s1_type;
  logic [COL_W-1:0] s1_col;
  logic [ROW_W-1:0] s1_row;

  // Result buffer: six indices shifted out one per handshake.
  logic              ob_valid;
  idx_t              ob_idx [NUM_IDX];
  logic [LEFT_W-1:0] ob_left;
  logic              ob_bad;

  logic out_fire, ob_free, s1_move, in_fire;

  assign out_fire = ob_valid && out_ready;
  assign ob_free  = !ob_valid || (out_fire && last);
  assign s1_move  = s1_valid && ob_free;
  assign in_ready = !rst && (!s1_valid || ob_free);
  assign in_fire  = in_valid && in_ready;

  // --------------------------------------------------------------------------
  // Index of face grid point (hx, hy). Edge points live in the first (top) or
  // last (bottom) side row; interior points in the face's own block.
  // --------------------------------------------------------------------------
  function automatic idx_t face_vertex(
    input logic [COL_W-1:0]  hx,
    input logic [ROW_W:0]    hy,
    input idx_t              ymul,   // (hy-1)*(R-2)
    input idx_t              off,
    input idx_t              base,
    input logic [RES_W-1:0]  n,
    input logic [RING_W-1:0] ring,
    input logic [RING_W-1:0] three
  );
    idx_t res;
    if (hy == '0) begin
      res = off + IDX_W'(hx);
    end else if (RING_W'(hy) == RING_W'(n)) begin
      res = off + IDX_W'(three) - IDX_W'(hx);
    end else if (hx == '0) begin
      res = off + IDX_W'(ring) - IDX_W'(hy);
    end else if (RING_W'(hx) == RING_W'(n)) begin
      res = off + IDX_W'(n) + IDX_W'(hy);
    end else begin
      res = base + IDX_W'(hx) - IDX_W'(1) + ymul;
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Index generation from the input register.
  // --------------------------------------------------------------------------
  logic              ok, bottom;
  idx_t              row_ring, row_inner;
  logic [RING_W-1:0] col_p1, b_col;
  idx_t              side_a, side_b;
  idx_t              off, base;
  logic [COL_W-1:0]  hx1;
  logic [ROW_W:0]    hy0, hy1;
  idx_t              p00, p10, p01, p11;
  idx_t              v_calc [NUM_IDX];

  always_comb begin
    if (s1_type == REQ_SIDE) begin
      ok = (RING_W'(s1_col) < ring_len) && (RES_W'(s1_row) < edge_n);
    end else if (s1_type == REQ_INVALID) begin
      ok = 1'b0;
    end else begin
      ok = (RING_W'(s1_col) < RING_W'(edge_n)) && (RES_W'(s1_row) < edge_n);
    end
    bottom = (s1_type == REQ_BOTTOM);

    row_ring  = IDX_W'(s1_row) * IDX_W'(ring_len);
    row_inner = IDX_W'(s1_row) * IDX_W'(inner_w);

    // side band, last column wraps onto the seam
    col_p1 = RING_W'(s1_col) + RING_W'(1);
    b_col  = (col_p1 == ring_len) ? '0 : col_p1;
    side_a = IDX_W'(s1_col) + row_ring;
    side_b = IDX_W'(b_col) + row_ring;

    // top and bottom faces
    off  = bottom ? bot_off : '0;
    base = bottom ? bot_base : top_base;
    hx1  = s1_col + COL_W'(1);
    hy0  = {1'b0, s1_row};
    hy1  = hy0 + (ROW_W + 1)'(1);
    p00  = face_vertex(s1_col, hy0, row_inner - IDX_W'(inner_w), off, base,
                       edge_n, ring_len, three_n);
    p10  = face_vertex(hx1, hy0, row_inner - IDX_W'(inner_w), off, base,
                       edge_n, ring_len, three_n);
    p01  = face_vertex(s1_col, hy1, row_inner, off, base,
                       edge_n, ring_len, three_n);
    p11  = face_vertex(hx1, hy1, row_inner, off, base,
                       edge_n, ring_len, three_n);

    for (int k = 0; k < NUM_IDX; k++) begin
      v_calc[k] = '0;
    end
    if (!ok) begin
      // rejected request: single zero index, already cleared above
    end else if (s1_type == REQ_SIDE) begin
      v_calc[0] = side_a;
      v_calc[1] = side_b;
      v_calc[2] = side_b + IDX_W'(ring_len);
      v_calc[3] = side_a;
      v_calc[4] = side_b + IDX_W'(ring_len);
      v_calc[5] = side_a + IDX_W'(ring_len);
    end else if (bottom) begin
      v_calc[0] = p00;
      v_calc[1] = p10;
      v_calc[2] = p11;
      v_calc[3] = p00;
      v_calc[4] = p11;
      v_calc[5] = p01;
    end else begin
      // top face: reversed winding
      v_calc[0] = p00;
      v_calc[1] = p11;
      v_calc[2] = p10;
      v_calc[3] = p11;
      v_calc[4] = p00;
      v_calc[5] = p01;
    end
  end

  // --------------------------------------------------------------------------
  // Control registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      ob_valid <= 1'b0;
      ob_left  <= '0;
    end else begin
      if (in_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end

      if (s1_move) begin
        ob_valid <= 1'b1;
        ob_left  <= ok ? LEFT_W'(NUM_IDX) : LEFT_W'(1);
      end else if (out_fire) begin
        ob_valid <= !last;
        ob_left  <= ob_left - LEFT_W'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers: capture the request, load or shift the result buffer.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_type <= req_t'(req_type);
      s1_col  <= quad_col;
      s1_row  <= quad_row;
    end

    if (s1_move) begin
      ob_idx <= v_calc;
      ob_bad <= !ok;
    end else if (out_fire) begin
      // advance to the next corner
      for (int k = 0; k < NUM_IDX - 1; k++) begin
        ob_idx[k] <= ob_idx[k+1];
      end
    end
  end

  assign out_valid   = ob_valid;
  assign vtx_index   = ob_idx[0];
  assign last        = (ob_left == LEFT_W'(1));
  assign bad_request = ob_bad;

endmodule
`default_nettype wire

FILE: src/csig_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csig_checker
// Port-level checks of the cube-sphere index generator, bound to the top.
// ----------------------------------------------------------------------------
module csig_checker
  import csig_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             cfg_ready,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [IDX_W-1:0] vtx_index,
  input wire logic             last,
  input wire logic             bad_request
);

  // hold off both input sides during reset
  a_no_ready_in_reset: assert property (@(posedge clk)
    rst |-> (!in_ready && !cfg_ready))
    else $error("ready high during reset");

  // a rejected request is one zero word that closes the request
  a_bad_word: assert property (@(posedge clk) disable iff (rst)
    (out_valid && bad_request) |-> (last && (vtx_index == '0)))
    else $error("bad request word malformed");

  // the corners of one request follow without a gap and are never flagged
  a_request_burst: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last) |=> (out_valid && !bad_request))
    else $error("request burst broken");

  // hold a stalled word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(vtx_index) && $stable(last) && $stable(bad_request)))
    else $error("stalled word changed");

endmodule

bind cube_sphere_index_generator csig_checker u_csig_checker (.*);
`default_nettype wire
